// ===== hdl/gccl_pkg.sv =====
// gccl_pkg: types, constants and helper functions for the grid cell cluster labeler
// used by gccl_datapath, gccl_ctrl and the top level; depends on nothing else
package gccl_pkg;

    localparam int MAX_CELLS  = 1024;
    localparam int FRAC_BITS  = 16;
    localparam int SLOT_BITS  = $clog2(MAX_CELLS);
    localparam int COUNT_BITS = SLOT_BITS + 1;
    localparam int SHIFT      = 2 * FRAC_BITS;
    localparam int EPOCH_BITS = 4;
    localparam int ENTRY_BITS = 3 * 32 + 10 + EPOCH_BITS;

    localparam logic [31:0] HASH_X = 32'h9E3779B1;
    localparam logic [31:0] HASH_Y = 32'h85EBCA77;
    localparam logic [31:0] HASH_Z = 32'hC2B2AE3D;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               first_of_set;
    } in_item_t;

    typedef struct packed {
        logic [9:0]  cell_tag;
        logic        new_cell;
        logic [10:0] cells_in_use;
        logic        overflow;
    } out_item_t;

    // an entry counts as stored only while its epoch matches the current set
    typedef struct packed {
        logic [31:0]           cx;
        logic [31:0]           cy;
        logic [31:0]           cz;
        logic [9:0]            tag;
        logic [EPOCH_BITS-1:0] epoch;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_CLEAR,
        ST_MUL,
        ST_CELL,
        ST_HASH,
        ST_READ,
        ST_WAIT,
        ST_CHECK,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic clear_step;
        logic do_mul;
        logic do_cell;
        logic do_hash;
        logic issue_read;
        logic advance;
        logic finish;
        logic out_take;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic resolved;
        logic out_full;
        logic wipe;
    } status_t;

    // product of the magnitude and scale, floored and saturated
    function automatic logic [31:0] to_cell(input logic neg, input logic [63:0] prod);
        logic [63:0] q;
        begin
            if (!neg)
            begin
                q = prod >> SHIFT;
                to_cell = (q > 64'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
            end
            else
            begin
                q = (prod + ((64'd1 << SHIFT) - 64'd1)) >> SHIFT;
                if (q > 64'h80000000)
                    q = 64'h80000000;
                to_cell = 32'd0 - q[31:0];
            end
        end
    endfunction

endpackage

// ===== hdl/gccl_ram.sv =====
// gccl_ram: generic single port RAM with registered read
// no dependencies
module gccl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

// ===== hdl/gccl_datapath.sv =====
// gccl_datapath: cell arithmetic, hash, probe logic, table epochs and result register
// depends on gccl_pkg and gccl_ram
module gccl_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  gccl_pkg::in_item_t  in_item,
    input  logic [31:0]         scale,
    input  gccl_pkg::cmd_t      cmd,
    output gccl_pkg::status_t   status,
    output gccl_pkg::out_item_t out_item
);
    localparam int SB = gccl_pkg::SLOT_BITS;
    localparam int CB = gccl_pkg::COUNT_BITS;
    localparam int EB = gccl_pkg::EPOCH_BITS;

    logic [31:0]   mag_reg [3];
    logic [2:0]    neg_reg;
    logic [63:0]   prod_reg [3];
    logic [31:0]   cell_reg [3];
    logic [31:0]   hx_reg, hy_reg, hz_reg;
    logic [SB-1:0] pos_reg, pos_next;
    logic [CB-1:0] probes_reg;
    logic [CB-1:0] next_tag_reg;
    logic [SB-1:0] clr_reg;
    logic [EB-1:0] epoch_reg;
    gccl_pkg::out_item_t out_reg;
    logic          out_full_reg;

    gccl_pkg::entry_t rd_entry, wr_entry, ins_entry;
    logic [SB-1:0]    ram_addr;
    logic             ram_we, ins_we;
    logic [31:0]      hsum, hash_mix;
    logic             hit, empty, full, exhausted;

    assign ins_entry = '{cx: cell_reg[0], cy: cell_reg[1], cz: cell_reg[2],
                         tag: next_tag_reg[9:0], epoch: epoch_reg};

    // the sweep stamps epoch zero, which no set ever uses
    assign wr_entry = cmd.clear_step ? gccl_pkg::entry_t'('0) : ins_entry;
    assign ram_addr = cmd.clear_step ? clr_reg : pos_reg;
    assign ram_we   = cmd.clear_step || ins_we;

    gccl_ram #(.WIDTH(gccl_pkg::ENTRY_BITS), .DEPTH(gccl_pkg::MAX_CELLS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (wr_entry),
        .rdata (rd_entry)
    );

    assign hsum     = hx_reg ^ hy_reg ^ hz_reg;
    assign hash_mix = hsum ^ (hsum >> 15);
    assign pos_next = (pos_reg == SB'(gccl_pkg::MAX_CELLS - 1)) ? '0 : pos_reg + 1'b1;

    assign empty     = rd_entry.epoch != epoch_reg;
    assign hit       = !empty && rd_entry.cx == cell_reg[0] && rd_entry.cy == cell_reg[1]
                       && rd_entry.cz == cell_reg[2];
    assign full      = next_tag_reg == CB'(gccl_pkg::MAX_CELLS);
    assign exhausted = probes_reg == CB'(gccl_pkg::MAX_CELLS - 1);
    assign ins_we    = cmd.finish && empty && !full;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            neg_reg <= {in_item.pos_z[31], in_item.pos_y[31], in_item.pos_x[31]};
            mag_reg[0] <= in_item.pos_x[31] ? 32'd0 - in_item.pos_x : in_item.pos_x;
            mag_reg[1] <= in_item.pos_y[31] ? 32'd0 - in_item.pos_y : in_item.pos_y;
            mag_reg[2] <= in_item.pos_z[31] ? 32'd0 - in_item.pos_z : in_item.pos_z;
        end
        if (cmd.do_mul)
            for (int i = 0; i < 3; i++)
                prod_reg[i] <= {32'd0, mag_reg[i]} * {32'd0, scale};
        if (cmd.do_cell)
            for (int i = 0; i < 3; i++)
                cell_reg[i] <= gccl_pkg::to_cell(neg_reg[i], prod_reg[i]);
        if (cmd.do_hash)
        begin
            hx_reg <= cell_reg[0] * gccl_pkg::HASH_X;
            hy_reg <= cell_reg[1] * gccl_pkg::HASH_Y;
            hz_reg <= cell_reg[2] * gccl_pkg::HASH_Z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_tag_reg <= '0;
            clr_reg      <= '0;
            epoch_reg    <= EB'(1);
            pos_reg      <= '0;
            probes_reg   <= '0;
            out_full_reg <= 1'b0;
            out_reg      <= '0;
        end
        else
        begin
            // a new set moves to the next epoch; past the last one the table is swept
            if (cmd.load_item && in_item.first_of_set)
            begin
                next_tag_reg <= '0;
                epoch_reg    <= (epoch_reg == '1) ? EB'(1) : epoch_reg + 1'b1;
            end
            if (cmd.clear_step)
                clr_reg <= clr_reg + 1'b1;
            if (cmd.do_hash)
                probes_reg <= '0;
            if (cmd.issue_read)
                pos_reg <= hash_mix[SB-1:0];
            if (cmd.advance)
            begin
                pos_reg    <= pos_next;
                probes_reg <= probes_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                out_full_reg <= 1'b1;
                if (hit)
                    out_reg <= '{cell_tag: rd_entry.tag, new_cell: 1'b0,
                                 cells_in_use: 11'(next_tag_reg), overflow: 1'b0};
                else if (empty && !full)
                begin
                    next_tag_reg <= next_tag_reg + 1'b1;
                    out_reg <= '{cell_tag: next_tag_reg[9:0], new_cell: 1'b1,
                                 cells_in_use: 11'(next_tag_reg + 1'b1), overflow: 1'b0};
                end
                else
                    out_reg <= '{cell_tag: 10'd0, new_cell: 1'b1,
                                 cells_in_use: 11'(next_tag_reg), overflow: 1'b1};
            end
            else if (cmd.out_take)
                out_full_reg <= 1'b0;
        end
    end

    // a probe is settled on a hit, an empty slot, or once every slot was seen
    assign status.resolved   = hit || empty || exhausted;
    assign status.clear_done = clr_reg == '1;
    assign status.out_full   = out_full_reg;
    // the offered item opens a set while the epochs are used up
    assign status.wipe       = in_item.first_of_set && epoch_reg == '1;
    assign out_item          = out_reg;
endmodule

// ===== hdl/gccl_ctrl.sv =====
// gccl_ctrl: sequencer for one vertex: sweep, scale, floor, hash, probe, write back
// depends on gccl_pkg
module gccl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              out_ready,
    input  gccl_pkg::status_t status,
    output gccl_pkg::cmd_t    cmd
);
    gccl_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gccl_pkg::ST_INIT;
        else
            state_reg <= state_next;
    end

    logic out_free;
    assign out_free = !status.out_full || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gccl_pkg::ST_INIT:  if (status.clear_done) state_next = gccl_pkg::ST_IDLE;
            gccl_pkg::ST_IDLE:
                if (in_valid)
                    state_next = status.wipe ? gccl_pkg::ST_CLEAR : gccl_pkg::ST_MUL;
            gccl_pkg::ST_CLEAR: if (status.clear_done) state_next = gccl_pkg::ST_MUL;
            gccl_pkg::ST_MUL:   state_next = gccl_pkg::ST_CELL;
            gccl_pkg::ST_CELL:  state_next = gccl_pkg::ST_HASH;
            gccl_pkg::ST_HASH:  state_next = gccl_pkg::ST_READ;
            gccl_pkg::ST_READ:  state_next = gccl_pkg::ST_WAIT;
            gccl_pkg::ST_WAIT:  state_next = gccl_pkg::ST_CHECK;
            gccl_pkg::ST_CHECK:
                if (status.resolved)
                    state_next = gccl_pkg::ST_OUT;
                else
                    state_next = gccl_pkg::ST_WAIT;
            gccl_pkg::ST_OUT:   if (out_free) state_next = gccl_pkg::ST_IDLE;
            default:            state_next = gccl_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            gccl_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
                cmd.out_take  = out_ready;
            end
            gccl_pkg::ST_INIT, gccl_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                cmd.out_take   = out_ready;
            end
            gccl_pkg::ST_MUL:   begin cmd.do_mul = 1'b1; cmd.out_take = out_ready; end
            gccl_pkg::ST_CELL:  begin cmd.do_cell = 1'b1; cmd.out_take = out_ready; end
            gccl_pkg::ST_HASH:  begin cmd.do_hash = 1'b1; cmd.out_take = out_ready; end
            gccl_pkg::ST_READ:  begin cmd.issue_read = 1'b1; cmd.out_take = out_ready; end
            gccl_pkg::ST_WAIT:  cmd.out_take = out_ready;
            gccl_pkg::ST_CHECK:
            begin
                cmd.out_take = out_ready;
                cmd.advance  = !status.resolved;
            end
            gccl_pkg::ST_OUT:
            begin
                cmd.out_take = out_ready;
                cmd.finish   = out_free;
            end
            default: cmd = '0;
        endcase
    end
endmodule

// ===== hdl/grid_cell_cluster_labeler.sv =====
// grid_cell_cluster_labeler: top level of the grid cell cluster labeler
// depends on gccl_pkg, gccl_ctrl, gccl_datapath and gccl_ram
//
//  channel   signals                      payload
//  in        in_valid / in_ready          in_item  (gccl_pkg::in_item_t)
//  out       out_valid / out_ready        out_item (gccl_pkg::out_item_t)
//  cfg       cfg_valid / cfg_ready        cfg_data (inv_cell_size)
//
// an item is scaled, floored to its cell, hashed and then linearly probed; the table memory port sets the probe rate
// a first-of-set item opens a new epoch; every fifteenth one sweeps the whole table first
// the result register frees the controller once the transfer out has been made or is made
// reset sweeps every table slot before the first transfer in; the scale resets to one
module grid_cell_cluster_labeler (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  gccl_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output gccl_pkg::out_item_t out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [31:0]         cfg_data
);
    gccl_pkg::cmd_t    cmd;
    gccl_pkg::status_t status;
    logic [31:0]       scale_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= 32'd65536;
        else if (cfg_valid)
            scale_reg <= cfg_data;
    end

    gccl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    gccl_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .scale    (scale_reg),
        .cmd      (cmd),
        .status   (status),
        .out_item (out_item)
    );

    assign out_valid = status.out_full;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.cells_in_use <= 11'd1024)
        else $error("tag count beyond table size");
    a_ovf_new: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.overflow |-> out_item.new_cell && out_item.cell_tag == 10'd0)
        else $error("overflow without new cell");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result dropped while stalled");
`endif
endmodule
